@@ hw/rtl/gcdm_pkg.sv @@
// Shared types, widths and codes for the greedy center distance matcher.
`timescale 1ns / 1ps
`default_nettype none
package gcdm_pkg;

   localparam int CoordWidth = 13;
   localparam int SizeWidth = 12;
   localparam int TrkCentreWidth = 14;
   localparam int DiffWidth = 15;
   localparam int DistWidth = 15;
   localparam int LimitWidth = 15;
   localparam int IdentWidth = 16;
   localparam int DetIdxWidth = 6;
   localparam int OpWidth = 2;
   localparam int MaxDetectionsDefault = 64;
   localparam logic [LimitWidth-1:0] LimitReset = 15'd30;

   typedef enum logic [OpWidth-1:0] {
      OP_CLEAR = 2'd0,
      OP_LOAD  = 2'd1,
      OP_MATCH = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic signed [CoordWidth-1:0] x;
      logic signed [CoordWidth-1:0] y;
   } centre_type;

endpackage
`default_nettype wire

@@ hw/rtl/gcdm_store.sv @@
// Detection center memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module gcdm_store #(
   parameter int DEPTH = gcdm_pkg::MaxDetectionsDefault
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [$clog2(DEPTH)-1:0]  wr_addr,
   input  gcdm_pkg::centre_type     wr_data,
   input  wire                      rd_en,
   input  wire [$clog2(DEPTH)-1:0]  rd_addr,
   output gcdm_pkg::centre_type     rd_data
);
   import gcdm_pkg::*;

   centre_type mem [DEPTH];
   centre_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ hw/rtl/gcdm_dist.sv @@
// Shared Manhattan distance unit with limit compare.
`timescale 1ns / 1ps
`default_nettype none
module gcdm_dist (
   input  wire signed [gcdm_pkg::TrkCentreWidth-1:0] trk_cx,
   input  wire signed [gcdm_pkg::TrkCentreWidth-1:0] trk_cy,
   input  gcdm_pkg::centre_type                      det,
   input  wire [gcdm_pkg::LimitWidth-1:0]            limit,
   output logic                                      in_limit
);
   import gcdm_pkg::*;

   logic signed [DiffWidth-1:0] dx;
   logic signed [DiffWidth-1:0] dy;
   logic [DiffWidth-2:0]        ax;
   logic [DiffWidth-2:0]        ay;
   logic [DistWidth-1:0]        manhattan;

   always_comb begin
      dx = DiffWidth'(trk_cx) - DiffWidth'(det.x);
      dy = DiffWidth'(trk_cy) - DiffWidth'(det.y);
      ax = dx[DiffWidth-1] ? (DiffWidth-1)'(-dx) : dx[DiffWidth-2:0];
      ay = dy[DiffWidth-1] ? (DiffWidth-1)'(-dy) : dy[DiffWidth-2:0];
      // max sum is about 20.5k, fits unsigned 15 bits
      manhattan = DistWidth'(ax) + DistWidth'(ay);
      in_limit = manhattan < limit;
   end

endmodule
`default_nettype wire

@@ hw/rtl/greedy_center_distance_matcher.sv @@
// Top level: request decode, scan sequencer, claim marks and response register.
// Clear and load take effect at the accepting edge. A match scans the loaded detections in
// order, ends early when a detection is claimed, and waits to register its response while
// rsp_stall holds the previous one back. Requests are stalled until that response is
// registered, so one match runs at a time; the scan is paced by the single read port of the
// center memory feeding the shared distance unit.
// Reset: synchronous, clears count, claim marks, limit (to 30) and response valid.
`timescale 1ns / 1ps
`default_nettype none
module greedy_center_distance_matcher #(
   parameter int MAX_DETECTIONS = gcdm_pkg::MaxDetectionsDefault
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire [gcdm_pkg::OpWidth-1:0]         req_operation,
   input  wire signed [gcdm_pkg::CoordWidth-1:0] req_det_left,
   input  wire signed [gcdm_pkg::CoordWidth-1:0] req_det_top,
   input  wire signed [gcdm_pkg::CoordWidth-1:0] req_det_right,
   input  wire signed [gcdm_pkg::CoordWidth-1:0] req_det_bottom,
   input  wire signed [gcdm_pkg::CoordWidth-1:0] req_trk_x,
   input  wire signed [gcdm_pkg::CoordWidth-1:0] req_trk_y,
   input  wire [gcdm_pkg::SizeWidth-1:0]       req_trk_width,
   input  wire [gcdm_pkg::SizeWidth-1:0]       req_trk_height,
   input  wire [gcdm_pkg::IdentWidth-1:0]      req_trk_ident,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output logic [gcdm_pkg::IdentWidth-1:0]     rsp_out_track_ident,
   output logic                                rsp_matched,
   output logic [gcdm_pkg::DetIdxWidth-1:0]    rsp_detection_index,
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire [gcdm_pkg::LimitWidth-1:0]      csr_match_distance_limit
);
   import gcdm_pkg::*;

   localparam int IdxW = $clog2(MAX_DETECTIONS);
   localparam int CntW = $clog2(MAX_DETECTIONS + 1);

   state_type                   state_ff, state_in;
   logic [CntW-1:0]             count_ff, count_in;
   logic [MAX_DETECTIONS-1:0]   claimed_ff, claimed_in;
   logic [LimitWidth-1:0]       limit_ff, limit_in;
   logic signed [TrkCentreWidth-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [IdentWidth-1:0]       ident_ff, ident_in;
   logic [IdxW-1:0]             issue_idx_ff, issue_idx_in;
   logic                        issuing_ff, issuing_in;
   logic                        chk_valid_ff, chk_valid_in;
   logic [IdxW-1:0]             chk_idx_ff, chk_idx_in;
   logic                        hit_ff, hit_in;
   logic [IdxW-1:0]             hit_idx_ff, hit_idx_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [IdentWidth-1:0]       rsp_ident_ff, rsp_ident_in;
   logic                        rsp_matched_ff, rsp_matched_in;
   logic [DetIdxWidth-1:0]      rsp_idx_ff, rsp_idx_in;

   logic                        wr_en;
   logic                        rd_en;
   centre_type                  wr_centre;
   centre_type                  rd_centre;
   logic                        in_limit;
   logic signed [CoordWidth:0]  sum_x, sum_y, adj_x, adj_y;
   op_type                      op;

   assign op = op_type'(req_operation);

   // centers: (a+b)/2 truncating toward zero
   always_comb begin
      sum_x = (CoordWidth+1)'(req_det_left) + (CoordWidth+1)'(req_det_right);
      sum_y = (CoordWidth+1)'(req_det_top) + (CoordWidth+1)'(req_det_bottom);
      adj_x = sum_x + (CoordWidth+1)'(sum_x[CoordWidth]);
      adj_y = sum_y + (CoordWidth+1)'(sum_y[CoordWidth]);
      wr_centre.x = adj_x[CoordWidth:1];
      wr_centre.y = adj_y[CoordWidth:1];
   end

   gcdm_store #(
      .DEPTH(MAX_DETECTIONS)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(count_ff[IdxW-1:0]),
      .wr_data(wr_centre),
      .rd_en  (rd_en),
      .rd_addr(issue_idx_ff),
      .rd_data(rd_centre)
   );

   gcdm_dist u_dist (
      .trk_cx  (cx_ff),
      .trk_cy  (cy_ff),
      .det     (rd_centre),
      .limit   (limit_ff),
      .in_limit(in_limit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         claimed_ff   <= '0;
         limit_ff     <= LimitReset;
         issuing_ff   <= 1'b0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         claimed_ff   <= claimed_in;
         limit_ff     <= limit_in;
         issuing_ff   <= issuing_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cx_ff          <= cx_in;
      cy_ff          <= cy_in;
      ident_ff       <= ident_in;
      issue_idx_ff   <= issue_idx_in;
      chk_idx_ff     <= chk_idx_in;
      hit_ff         <= hit_in;
      hit_idx_ff     <= hit_idx_in;
      rsp_ident_ff   <= rsp_ident_in;
      rsp_matched_ff <= rsp_matched_in;
      rsp_idx_ff     <= rsp_idx_in;
   end

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      claimed_in     = claimed_ff;
      limit_in       = limit_ff;
      cx_in          = cx_ff;
      cy_in          = cy_ff;
      ident_in       = ident_ff;
      issue_idx_in   = issue_idx_ff;
      issuing_in     = issuing_ff;
      chk_valid_in   = 1'b0;
      chk_idx_in     = issue_idx_ff;
      hit_in         = hit_ff;
      hit_idx_in     = hit_idx_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_ident_in   = rsp_ident_ff;
      rsp_matched_in = rsp_matched_ff;
      rsp_idx_in     = rsp_idx_ff;
      wr_en          = 1'b0;
      rd_en          = 1'b0;

      if (csr_valid && csr_ready) begin
         limit_in = csr_match_distance_limit;
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (op)
                  OP_CLEAR: begin
                     count_in   = '0;
                     claimed_in = '0;
                  end
                  OP_LOAD: begin
                     if (count_ff < CntW'(MAX_DETECTIONS)) begin
                        wr_en = 1'b1;
                        claimed_in[count_ff[IdxW-1:0]] = 1'b0;
                        count_in = count_ff + CntW'(1);
                     end
                  end
                  OP_MATCH: begin
                     cx_in = TrkCentreWidth'(req_trk_x) +
                             TrkCentreWidth'(req_trk_width[SizeWidth-1:1]);
                     cy_in = TrkCentreWidth'(req_trk_y) +
                             TrkCentreWidth'(req_trk_height[SizeWidth-1:1]);
                     ident_in     = req_trk_ident;
                     hit_in       = 1'b0;
                     hit_idx_in   = '0;
                     issue_idx_in = '0;
                     issuing_in   = (count_ff != '0);
                     state_in     = (count_ff != '0) ? ST_SCAN : ST_DONE;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // read pipeline: address issued in the cycle before its compare
            if (issuing_ff) begin
               rd_en        = 1'b1;
               chk_valid_in = 1'b1;
               chk_idx_in   = issue_idx_ff;
               issue_idx_in = IdxW'(CntW'(issue_idx_ff) + CntW'(1));
               if ((CntW'(issue_idx_ff) + CntW'(1)) == count_ff) begin
                  issuing_in = 1'b0;
               end
            end
            if (chk_valid_ff) begin
               if (!claimed_ff[chk_idx_ff] && in_limit) begin
                  claimed_in[chk_idx_ff] = 1'b1;
                  hit_in       = 1'b1;
                  hit_idx_in   = chk_idx_ff;
                  issuing_in   = 1'b0;
                  chk_valid_in = 1'b0;
                  state_in     = ST_DONE;
               end else if ((CntW'(chk_idx_ff) + CntW'(1)) == count_ff) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_ident_in   = ident_ff;
               rsp_matched_in = hit_ff;
               rsp_idx_in     = DetIdxWidth'(hit_idx_ff);
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall           = (state_ff != ST_IDLE);
   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_out_track_ident = rsp_ident_ff;
   assign rsp_matched         = rsp_matched_ff;
   assign rsp_detection_index = rsp_idx_ff;

   a_unmatched_index_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_matched_ff) |-> (rsp_idx_ff == '0))
      else $error("unmatched response carries nonzero index");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(MAX_DETECTIONS))
      else $error("loaded count exceeds capacity");

   a_scan_needs_entries: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (count_ff != '0))
      else $error("scan with empty store");

   a_check_in_range: assert property (@(posedge clock) disable iff (reset)
      chk_valid_ff |-> (CntW'(chk_idx_ff) < count_ff))
      else $error("compare of an unloaded entry");

   a_one_claim: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |=>
         ($countones(claimed_ff) <= $countones($past(claimed_ff)) + 1))
      else $error("more than one claim in a cycle");

endmodule
`default_nettype wire

@@ dv/greedy_center_distance_matcher_test.sv @@
// Testbench for the greedy center distance matcher: directed and random request streams.
`timescale 1ns / 1ps
module greedy_center_distance_matcher_test;
   import gcdm_pkg::*;

   localparam int MaxDet = MaxDetectionsDefault;
   localparam logic [OpWidth-1:0] OpUnused = 2'd3;
   localparam int CoordMin = -4096;
   localparam int CoordMax = 4095;
   localparam int SizeMax = 4095;
   localparam int IdlePause = 16;
   localparam int HoldCycles = 400;
   localparam int WatchdogLimit = 5000;
   localparam int MaxReported = 10;

   typedef struct {
      logic [OpWidth-1:0] op;
      logic signed [CoordWidth-1:0] left, top, right, bottom, trk_x, trk_y;
      logic [SizeWidth-1:0] trk_w, trk_h;
      logic [IdentWidth-1:0] ident;
   } request_type;

   typedef struct {
      logic [IdentWidth-1:0] ident;
      logic matched;
      logic [DetIdxWidth-1:0] index;
   } track_result_type;

   typedef enum {STALL_NONE, STALL_SPARSE, STALL_PERIODIC, STALL_HEAVY} stall_mode_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [OpWidth-1:0] req_operation;
   logic signed [CoordWidth-1:0] req_det_left, req_det_top, req_det_right, req_det_bottom;
   logic signed [CoordWidth-1:0] req_trk_x, req_trk_y;
   logic [SizeWidth-1:0] req_trk_width, req_trk_height;
   logic [IdentWidth-1:0] req_trk_ident;
   logic rsp_valid;
   logic rsp_stall;
   logic [IdentWidth-1:0] rsp_out_track_ident;
   logic rsp_matched;
   logic [DetIdxWidth-1:0] rsp_detection_index;
   logic csr_valid;
   logic csr_ready;
   logic [LimitWidth-1:0] csr_match_distance_limit;

   // predictor state
   int centre_x_seen[MaxDet];
   int centre_y_seen[MaxDet];
   bit claimed[MaxDet];
   int det_count;
   int distance_limit;
   track_result_type awaited_matches[$];

   int mismatch_count;
   int requests_sent;
   int burst_left;
   bit gapless;
   bit holdoff_request = 1'b0;
   int cluster_x, cluster_y;

   greedy_center_distance_matcher #(.MAX_DETECTIONS(MaxDet)) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_operation(req_operation),
      .req_det_left(req_det_left),
      .req_det_top(req_det_top),
      .req_det_right(req_det_right),
      .req_det_bottom(req_det_bottom),
      .req_trk_x(req_trk_x),
      .req_trk_y(req_trk_y),
      .req_trk_width(req_trk_width),
      .req_trk_height(req_trk_height),
      .req_trk_ident(req_trk_ident),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_track_ident(rsp_out_track_ident),
      .rsp_matched(rsp_matched),
      .rsp_detection_index(rsp_detection_index),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_match_distance_limit(csr_match_distance_limit)
   );

   always #10 clock = ~clock;

   // Applies one accepted request to the predicted store; returns 1 when a response is due.
   function automatic bit track_outcome(input request_type r, output track_result_type res);
      int cx, cy, sep;
      res = '{ident: r.ident, matched: 1'b0, index: '0};
      case (r.op)
         OP_CLEAR: begin
            det_count = 0;
            foreach (claimed[i]) claimed[i] = 1'b0;
         end
         OP_LOAD: begin
            if (det_count < MaxDet) begin
               // SV integer division truncates toward zero
               centre_x_seen[det_count] = (int'(r.left) + int'(r.right)) / 2;
               centre_y_seen[det_count] = (int'(r.top) + int'(r.bottom)) / 2;
               claimed[det_count] = 1'b0;
               det_count++;
            end
         end
         OP_MATCH: begin
            cx = int'(r.trk_x) + int'(r.trk_w >> 1);
            cy = int'(r.trk_y) + int'(r.trk_h >> 1);
            for (int i = 0; i < det_count; i++) begin
               if (!claimed[i]) begin
                  sep = (cx > centre_x_seen[i] ? cx - centre_x_seen[i] : centre_x_seen[i] - cx)
                      + (cy > centre_y_seen[i] ? cy - centre_y_seen[i] : centre_y_seen[i] - cy);
                  if (sep < distance_limit) begin
                     claimed[i] = 1'b1;
                     res.matched = 1'b1;
                     res.index = DetIdxWidth'(i);
                     break;
                  end
               end
            end
            return 1'b1;
         end
         default: ;
      endcase
      return 1'b0;
   endfunction

   function automatic int rand_coord();
      case ($urandom_range(0, 7))
         0: return CoordMin;
         1: return CoordMax;
         default: return int'($urandom_range(0, 8191)) - 4096;
      endcase
   endfunction

   function automatic int rand_size();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return SizeMax;
         default: return int'($urandom_range(0, SizeMax));
      endcase
   endfunction

   function automatic int clamp_coord(input int v);
      return (v < CoordMin) ? CoordMin : (v > CoordMax) ? CoordMax : v;
   endfunction

   function automatic request_type op_request(input logic [OpWidth-1:0] op);
      request_type r;
      r.op = op;
      r.left = CoordWidth'($urandom);
      r.top = CoordWidth'($urandom);
      r.right = CoordWidth'($urandom);
      r.bottom = CoordWidth'($urandom);
      r.trk_x = CoordWidth'($urandom);
      r.trk_y = CoordWidth'($urandom);
      r.trk_w = SizeWidth'($urandom);
      r.trk_h = SizeWidth'($urandom);
      r.ident = IdentWidth'($urandom);
      return r;
   endfunction

   function automatic request_type load_box(input int l, input int t, input int rt, input int b);
      request_type r;
      r = op_request(OP_LOAD);
      r.left = CoordWidth'(l);
      r.top = CoordWidth'(t);
      r.right = CoordWidth'(rt);
      r.bottom = CoordWidth'(b);
      return r;
   endfunction

   function automatic request_type track_request(input int x, input int y, input int w,
                                                 input int h, input int ident);
      request_type r;
      r = op_request(OP_MATCH);
      r.trk_x = CoordWidth'(x);
      r.trk_y = CoordWidth'(y);
      r.trk_w = SizeWidth'(w);
      r.trk_h = SizeWidth'(h);
      r.ident = IdentWidth'(ident);
      return r;
   endfunction

   // Boxes are either wild edges, a fresh center, or clustered near the last one.
   function automatic request_type random_box();
      int hw, hh;
      case ($urandom_range(0, 2))
         0: return load_box(rand_coord(), rand_coord(), rand_coord(), rand_coord());
         1: begin
            cluster_x = rand_coord();
            cluster_y = rand_coord();
         end
         default: begin
            cluster_x = clamp_coord(cluster_x + int'($urandom_range(0, 80)) - 40);
            cluster_y = clamp_coord(cluster_y + int'($urandom_range(0, 80)) - 40);
         end
      endcase
      hw = $urandom_range(0, 40);
      hh = $urandom_range(0, 40);
      return load_box(clamp_coord(cluster_x - hw), clamp_coord(cluster_y - hh),
                      clamp_coord(cluster_x + hw + int'($urandom_range(0, 1))),
                      clamp_coord(cluster_y + hh + int'($urandom_range(0, 1))));
   endfunction

   function automatic request_type random_track();
      return track_request(rand_coord(), rand_coord(), rand_size(), rand_size(),
                           $urandom_range(0, 65535));
   endfunction

   // Track centered at a chosen distance from a loaded detection, often right at the limit.
   function automatic request_type near_track();
      int idx, d, dx, span, cx, cy, w, h, x, y;
      if (det_count == 0)
         return random_track();
      idx = $urandom_range(0, det_count - 1);
      span = (distance_limit == 0) ? 4 : (distance_limit > 3000) ? 3000 : distance_limit;
      case ($urandom_range(0, 3))
         0: d = distance_limit;
         1: d = (distance_limit > 0) ? distance_limit - 1 : 0;
         default: d = $urandom_range(0, 2 * span);
      endcase
      dx = $urandom_range(0, d);
      cx = centre_x_seen[idx] + ($urandom_range(0, 1) ? dx : -dx);
      cy = centre_y_seen[idx] + ($urandom_range(0, 1) ? d - dx : dx - d);
      w = rand_size();
      h = rand_size();
      x = cx - w / 2;
      y = cy - h / 2;
      if (x < CoordMin || x > CoordMax) begin
         w = 0;
         x = clamp_coord(cx);
      end
      if (y < CoordMin || y > CoordMax) begin
         h = 0;
         y = clamp_coord(cy);
      end
      return track_request(x, y, w, h, $urandom_range(0, 65535));
   endfunction

   // Offers one request, waits for acceptance, and leaves valid high unless a gap follows.
   task automatic send_request(input request_type r);
      track_result_type res;
      int gap;
      req_valid <= 1'b1;
      req_operation <= r.op;
      req_det_left <= r.left;
      req_det_top <= r.top;
      req_det_right <= r.right;
      req_det_bottom <= r.bottom;
      req_trk_x <= r.trk_x;
      req_trk_y <= r.trk_y;
      req_trk_width <= r.trk_w;
      req_trk_height <= r.trk_h;
      req_trk_ident <= r.ident;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (track_outcome(r, res))
         awaited_matches = {awaited_matches, res};
      if (r.op != OpUnused)
         requests_sent++;
      @(negedge clock);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 24);
         if (gapless || $urandom_range(0, 3) == 0)
            gap = 0;
         else if ($urandom_range(0, 7) == 0)
            gap = $urandom_range(7, 80);
         else
            gap = $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   // Only while idle: all responses in, then a short pause for trailing loads.
   task automatic write_match_limit(input int value);
      req_valid <= 1'b0;
      while (awaited_matches.size() != 0) @(negedge clock);
      repeat (IdlePause) @(negedge clock);
      csr_valid <= 1'b1;
      csr_match_distance_limit <= LimitWidth'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      distance_limit = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_reset_limit();
      send_request(track_request(CoordMin, CoordMin, 0, 0, 16'hFFFF));   // empty store
      send_request(load_box(CoordMin, CoordMin, CoordMax, CoordMax));    // center (0,0)
      send_request(load_box(CoordMin, CoordMin, CoordMin, CoordMin));
      send_request(load_box(CoordMax, CoordMax, CoordMax, CoordMax));
      send_request(load_box(-3, -3, 0, 0));                              // rounds to -1, not -2
      send_request(load_box(100, 0, 101, 1));                            // center (100,0)
      send_request(track_request(CoordMax, CoordMax, SizeMax, SizeMax, 16'hFFFF));
      send_request(track_request(CoordMax, CoordMax, 0, 0, 0));
      send_request(track_request(CoordMax, CoordMax, 0, 0, 1));          // already claimed
      // first within limit wins over the exact hit loaded later
      send_request(track_request(-1, -1, 0, 0, 2));
      send_request(track_request(-1, -1, 0, 0, 3));
      send_request(track_request(100, 10, 21, 21, 4));                   // distance == limit
      send_request(track_request(100, 9, 21, 21, 5));                    // one below limit
      send_request(op_request(OpUnused));
      send_request(track_request(100, 0, 0, 0, 6));
      send_request(track_request(CoordMin, CoordMin, 0, 1, 7));
      send_request(op_request(OP_CLEAR));
      send_request(track_request(0, 0, 0, 0, 8));
   endtask

   task automatic test_limit_extremes();
      write_match_limit(0);
      send_request(load_box(5, 5, 5, 5));
      send_request(track_request(5, 5, 0, 0, 9));                        // zero limit never matches
      write_match_limit(32767);
      send_request(track_request(CoordMin, CoordMin, 0, 0, 10));
      send_request(load_box(CoordMin, CoordMin, CoordMin, CoordMin));
      send_request(track_request(CoordMax, CoordMax, SizeMax, SizeMax, 11));
      send_request(op_request(OP_CLEAR));
   endtask

   // Clear, load a batch, then mostly tracks near loaded detections with some noise mixed in.
   task automatic run_random_frame();
      int loads, tracks;
      send_request(op_request(OP_CLEAR));
      if ($urandom_range(0, 9) == 0)
         loads = $urandom_range(MaxDet - 8, MaxDet + 6);
      else
         loads = $urandom_range(1, 12);
      for (int i = 0; i < loads; i++)
         send_request(random_box());
      tracks = $urandom_range(1, loads + 4);
      for (int i = 0; i < tracks; i++) begin
         case ($urandom_range(0, 19))
            0: send_request(op_request(OpUnused));
            1: send_request(random_box());
            2: send_request(random_track());
            3: send_request($urandom_range(0, 3) == 0 ? op_request(OP_CLEAR) : random_track());
            default: send_request(near_track());
         endcase
      end
   endtask

   task automatic test_random_frames(input int limit, input int budget);
      int start;
      write_match_limit(limit);
      start = requests_sent;
      while (requests_sent - start < budget)
         run_random_frame();
   endtask

   task automatic test_response_holdoff();
      gapless = 1'b1;
      holdoff_request = 1'b1;
      send_request(op_request(OP_CLEAR));
      for (int i = 0; i < 6; i++)
         send_request(random_box());
      for (int i = 0; i < 30; i++)
         send_request(near_track());
      gapless = 1'b0;
   endtask

   always @(posedge clock) begin : check_response
      track_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_matches.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MaxReported)
               $display("unexpected response: ident %0d matched %0b index %0d",
                        rsp_out_track_ident, rsp_matched, rsp_detection_index);
         end else begin
            want = awaited_matches.pop_front();
            if (rsp_out_track_ident !== want.ident || rsp_matched !== want.matched ||
                rsp_detection_index !== want.index) begin
               mismatch_count++;
               if (mismatch_count <= MaxReported)
                  $display("mismatch: expected ident %0d matched %0b index %0d, got %0d %0b %0d",
                           want.ident, want.matched, want.index,
                           rsp_out_track_ident, rsp_matched, rsp_detection_index);
            end
         end
      end
   end

   initial begin : receiver
      int hold_left, mode_left, tick;
      stall_mode_type mode;
      hold_left = 0;
      mode_left = 0;
      tick = 0;
      mode = STALL_NONE;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (holdoff_request) begin
            holdoff_request = 1'b0;
            hold_left = HoldCycles;
         end
         if (mode_left == 0) begin
            mode = stall_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         tick++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (mode)
               STALL_NONE: rsp_stall <= 1'b0;
               STALL_SPARSE: rsp_stall <= ($urandom_range(0, 9) < 3);
               STALL_PERIODIC: rsp_stall <= ((tick % 7) < 2);
               default: rsp_stall <= ($urandom_range(0, 9) < 7);
            endcase
         end
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WatchdogLimit) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("greedy_center_distance_matcher_test NOT OK");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = OP_CLEAR;
      req_det_left = '0;
      req_det_top = '0;
      req_det_right = '0;
      req_det_bottom = '0;
      req_trk_x = '0;
      req_trk_y = '0;
      req_trk_width = '0;
      req_trk_height = '0;
      req_trk_ident = '0;
      csr_valid = 1'b0;
      csr_match_distance_limit = '0;
      det_count = 0;
      distance_limit = int'(LimitReset);
      foreach (claimed[i]) claimed[i] = 1'b0;
      mismatch_count = 0;
      requests_sent = 0;
      burst_left = 1;
      gapless = 1'b0;
      cluster_x = 0;
      cluster_y = 0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_limit();
      test_limit_extremes();
      test_random_frames(30, 260);
      test_random_frames(1, 200);
      test_random_frames($urandom_range(2, 80), 300);
      test_random_frames($urandom_range(500, 3000), 260);
      test_random_frames($urandom_range(0, 32767), 250);
      test_random_frames(0, 160);
      test_random_frames(32767, 250);
      test_response_holdoff();

      req_valid <= 1'b0;
      while (awaited_matches.size() != 0) @(negedge clock);
      repeat (IdlePause) @(negedge clock);
      if (mismatch_count == 0 && awaited_matches.size() == 0)
         $display("greedy_center_distance_matcher_test OK");
      else
         $display("greedy_center_distance_matcher_test NOT OK");
      $finish;
   end

endmodule
